[design/trls_pkg.sv]
// Shared constants for the throttle range learning and scaling block.
// No dependencies; imported by throttle_range_learn_scale.
package trls_pkg;

  localparam int SAMPLE_W          = 12;
  localparam int PCT_W             = 7;
  localparam int NUM_W             = 19;   // holds 100 * 4095
  localparam int IN_DATA_W         = 16;
  localparam int OUT_DATA_W        = 40;
  localparam int CFG_IDX_W         = 1;
  localparam int SAMPLE_FULL_SCALE = 4095;

  localparam logic [PCT_W-1:0]    PERCENT_MAX  = 7'd100;
  localparam logic [SAMPLE_W-1:0] LOW_THR_RST  = 12'd600;
  localparam logic [SAMPLE_W-1:0] HIGH_THR_RST = 12'd2000;
  localparam logic [SAMPLE_W-1:0] LOW_RST      = 12'd4095;
  localparam logic [SAMPLE_W-1:0] HIGH_RST     = 12'd0;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_DIV   = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

endpackage

[design/throttle_range_learn_scale.sv]
// Throttle range learning and percent scaling, top level.
// Depends on trls_pkg.
//
// One 12-bit throttle sample per request updates the learned minimum and maximum and the
// sticky learned flags, then is scaled to 0..100 percent. The learned span is used while the
// learned minimum is below the low threshold or the learned maximum is above the high
// threshold, else SAMPLE_FULL_SCALE. The scaling runs on one shared subtract-and-compare
// unit: one overflow check and seven restoring division steps. Samples at or outside the
// span, and a zero span, skip the division and give a result in the cycle after acceptance.
// A fixed-scale quotient of 128 or more saturates at the overflow check. The input side is
// not ready from acceptance until the result is taken, so the block does not take a new
// sample before it is through with the last one. Threshold writes are always accepted and
// act on the next sample.
module throttle_range_learn_scale #(
  parameter int SAMPLE_FULL_SCALE = trls_pkg::SAMPLE_FULL_SCALE
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [11:0] throttle_sample, [15:12] zero
  input  logic [trls_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [6:0] throttle_percent, [7] low_end_learned, [8] high_end_learned,
  // [9] fully_calibrated, [21:10] span_minimum, [33:22] span_maximum, [39:34] zero
  output logic [trls_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [trls_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [trls_pkg::SAMPLE_W-1:0]     cfg_data
);
  import trls_pkg::*;

  localparam int FW    = $clog2(SAMPLE_FULL_SCALE + 1);
  localparam int DEN_W = (FW > SAMPLE_W) ? FW : SAMPLE_W;
  localparam int DSH_W = DEN_W + PCT_W;

  state_t               state_r, state_nxt;
  logic [SAMPLE_W-1:0]  low_thr_r, high_thr_r;
  logic [SAMPLE_W-1:0]  low_r, low_nxt, high_r, high_nxt;
  logic                 low_flag_r, low_flag_nxt, high_flag_r, high_flag_nxt;
  logic [NUM_W-1:0]     rem_r, rem_nxt;
  logic [DSH_W-1:0]     dsh_r, dsh_nxt;
  logic [PCT_W-1:0]     q_r, q_nxt;
  logic [PCT_W-1:0]     pct_r, pct_nxt;
  logic [2:0]           cnt_r, cnt_nxt;

  logic [SAMPLE_W-1:0]  s;
  logic                 in_acc;
  logic                 span_mode;
  logic [NUM_W-1:0]     num;
  logic [DEN_W-1:0]     den;
  logic [DSH_W:0]       diff;
  logic                 fits;
  logic [PCT_W-1:0]     q_last;

  assign s         = in_tdata[SAMPLE_W-1:0];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Shared unit: trial subtract of the shifted divisor from the partial remainder
  assign diff   = {1'b0, DSH_W'(rem_r)} - {1'b0, dsh_r};
  assign fits   = !diff[DSH_W];
  assign q_last = {q_r[PCT_W-2:0], fits};

  always_comb begin
    low_nxt       = low_r;
    high_nxt      = high_r;
    low_flag_nxt  = low_flag_r;
    high_flag_nxt = high_flag_r;
    if (s < low_r) begin
      low_nxt = s;
      if (s < low_thr_r) low_flag_nxt = 1'b1;
    end
    if (s > high_r) begin
      high_nxt = s;
      if (s > high_thr_r) high_flag_nxt = 1'b1;
    end
    span_mode = (low_nxt < low_thr_r) || (high_nxt > high_thr_r);
    if (span_mode) begin
      num = NUM_W'(s - low_nxt) * NUM_W'(PERCENT_MAX);
      den = DEN_W'(high_nxt - low_nxt);
    end else begin
      num = NUM_W'(s) * NUM_W'(PERCENT_MAX);
      den = DEN_W'(SAMPLE_FULL_SCALE);
    end
  end

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    dsh_nxt   = dsh_r;
    q_nxt     = q_r;
    pct_nxt   = pct_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          rem_nxt   = num;
          dsh_nxt   = {den, {PCT_W{1'b0}}};
          q_nxt     = '0;
          state_nxt = S_CHECK;
          if (span_mode) begin
            // zero span and samples at the span ends resolve without division
            if (high_nxt <= low_nxt || s <= low_nxt) begin
              pct_nxt   = '0;
              state_nxt = S_DONE;
            end else if (s >= high_nxt) begin
              pct_nxt   = PERCENT_MAX;
              state_nxt = S_DONE;
            end
          end
        end
      end
      S_CHECK: begin
        // quotient of 128 or more saturates
        if (fits) begin
          pct_nxt   = PERCENT_MAX;
          state_nxt = S_DONE;
        end else begin
          dsh_nxt   = dsh_r >> 1;
          cnt_nxt   = 3'd6;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (fits) rem_nxt = diff[NUM_W-1:0];
        q_nxt   = q_last;
        dsh_nxt = dsh_r >> 1;
        cnt_nxt = cnt_r - 3'd1;
        if (cnt_r == 3'd0) begin
          pct_nxt   = (q_last > PERCENT_MAX) ? PERCENT_MAX : q_last;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      low_thr_r   <= LOW_THR_RST;
      high_thr_r  <= HIGH_THR_RST;
      low_r       <= LOW_RST;
      high_r      <= HIGH_RST;
      low_flag_r  <= 1'b0;
      high_flag_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (in_acc) begin
        low_r       <= low_nxt;
        high_r      <= high_nxt;
        low_flag_r  <= low_flag_nxt;
        high_flag_r <= high_flag_nxt;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_LOW_THR:  low_thr_r  <= cfg_data;
          CFG_HIGH_THR: high_thr_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
    pct_r <= pct_nxt;
  end

  assign out_tvalid = (state_r == S_DONE);
  assign out_tdata  = {6'd0, high_r, low_r, low_flag_r & high_flag_r,
                       high_flag_r, low_flag_r, pct_r};

endmodule

[tb/tb_top.sv]
// Testbench for throttle_range_learn_scale: drives throttle samples and threshold writes,
// predicts each percent result and learned range, and checks every result in order.
// Depends on trls_pkg and the throttle_range_learn_scale RTL.
`timescale 1ns / 100ps

module tb_top;
  import trls_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int MAX_REPORTS    = 10;

  // Fields of one result, last field in the lowest bits
  typedef struct packed {
    logic [SAMPLE_W-1:0] span_max;
    logic [SAMPLE_W-1:0] span_min;
    logic                both_learned;
    logic                high_learned;
    logic                low_learned;
    logic [PCT_W-1:0]    percent;
  } throttle_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [SAMPLE_W-1:0]   cfg_data;

  // Predicted block state and thresholds
  int unsigned thr_low;
  int unsigned thr_high;
  int unsigned range_low;
  int unsigned range_high;
  bit          low_seen;
  bit          high_seen;

  throttle_result_t pending_results[$];
  int               mismatches;
  bit               no_idle;
  int               hold_request;
  int               idle_cycles;
  throttle_result_t got_result;
  throttle_result_t want_result;

  throttle_range_learn_scale dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Update the learned range for one sample and queue the result it should give
  task automatic learn_and_scale(input logic [SAMPLE_W-1:0] sample);
    int unsigned s;
    int unsigned pct;
    throttle_result_t res;
    s = sample;
    if (s < range_low) begin
      range_low = s;
      if (range_low < thr_low) low_seen = 1'b1;
    end
    if (s > range_high) begin
      range_high = s;
      if (range_high > thr_high) high_seen = 1'b1;
    end
    if (range_low < thr_low || range_high > thr_high) begin
      if (range_high <= range_low || s <= range_low) begin
        pct = 0;
      end else if (s >= range_high) begin
        pct = 100;
      end else begin
        pct = (100 * (s - range_low)) / (range_high - range_low);
      end
    end else begin
      pct = (100 * s) / SAMPLE_FULL_SCALE;
    end
    if (pct > 100) pct = 100;
    res.percent      = pct[PCT_W-1:0];
    res.low_learned  = low_seen;
    res.high_learned = high_seen;
    res.both_learned = low_seen & high_seen;
    res.span_min     = range_low[SAMPLE_W-1:0];
    res.span_max     = range_high[SAMPLE_W-1:0];
    pending_results.push_back(res);
  endtask

  task automatic flag_mismatch(input string field, input int unsigned want,
                               input int unsigned got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
  endtask

  // Check every accepted result against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_result = throttle_result_t'(out_tdata[$bits(throttle_result_t)-1:0]);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with no request outstanding, data %h", $realtime, out_tdata);
      end else begin
        want_result = pending_results.pop_front();
        if (got_result.percent != want_result.percent)
          flag_mismatch("throttle_percent", want_result.percent, got_result.percent);
        if (got_result.low_learned != want_result.low_learned)
          flag_mismatch("low_end_learned", want_result.low_learned, got_result.low_learned);
        if (got_result.high_learned != want_result.high_learned)
          flag_mismatch("high_end_learned", want_result.high_learned,
                        got_result.high_learned);
        if (got_result.both_learned != want_result.both_learned)
          flag_mismatch("fully_calibrated", want_result.both_learned,
                        got_result.both_learned);
        if (got_result.span_min != want_result.span_min)
          flag_mismatch("span_minimum", want_result.span_min, got_result.span_min);
        if (got_result.span_max != want_result.span_max)
          flag_mismatch("span_maximum", want_result.span_max, got_result.span_max);
      end
    end
  end

  // Receiver: random stall per result, or one long hold-off when a test asks for it
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // End the run if nothing moves on any channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-SAMPLE_W){1'b0}}, sample};
    do @(posedge clk); while (!in_tready);
    learn_and_scale(sample);
  endtask

  // Drop the request line and wait until the block has returned every result
  task automatic wait_all_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [SAMPLE_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_LOW_THR) thr_low = value;
    else thr_high = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_thresholds(input logic [SAMPLE_W-1:0] low_thr,
                                input logic [SAMPLE_W-1:0] high_thr);
    wait_all_results();
    write_threshold(CFG_LOW_THR, low_thr);
    write_threshold(CFG_HIGH_THR, high_thr);
  endtask

  // First sample after reset lands above the high threshold: zero span gives 0
  task automatic test_zero_span();
    send_sample(12'd3000);
    send_sample(12'd3000);
    send_sample(12'd2500);
    send_sample(12'd2800);
  endtask

  // Thresholds at the extremes keep span scaling off: fixed full-scale percent
  task automatic test_fixed_scale();
    set_thresholds(12'd0, 12'd4095);
    send_sample(12'd4095);
    send_sample(12'd2000);
    send_sample(12'd2047);
    send_sample(12'd1234);
  endtask

  // New minimum crosses the low threshold: low flag sets, span scaling takes over
  task automatic test_low_end_learning();
    set_thresholds(12'd1000, 12'd4095);
    send_sample(12'd1500);
    send_sample(12'd999);
    send_sample(12'd2000);
    send_sample(12'd4094);
    send_sample(12'd1);
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd2048);
    set_thresholds(12'd4095, 12'd0);
    send_sample(12'd1365);
    send_sample(12'd2730);
    set_thresholds(LOW_THR_RST, HIGH_THR_RST);
    send_sample(12'd3071);
  endtask

  // Hold the result side off long enough that the input side stalls
  task automatic test_receiver_hold();
    no_idle = 1'b1;
    hold_request = 80;
    repeat (12) send_sample(12'($urandom_range(0, 4095)));
    no_idle = 1'b0;
  endtask

  // Sender waits for every result before each new request
  task automatic test_sender_pause();
    repeat (5) begin
      send_sample(12'($urandom_range(0, 4095)));
      wait_all_results();
    end
  endtask

  task automatic test_random_phases();
    int mode;
    for (int phase = 0; phase < 12; phase++) begin
      mode = $urandom_range(0, 3);
      case (mode)
        0: set_thresholds(12'd0, 12'd4095);
        1: set_thresholds(12'd4095, 12'd0);
        2: set_thresholds(LOW_THR_RST, HIGH_THR_RST);
        default: set_thresholds(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (50) begin
        if ($urandom_range(0, 7) == 0)
          send_sample($urandom_range(0, 1) ? 12'd4095 : 12'd0);
        else
          send_sample(12'($urandom_range(0, 4095)));
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_LOW_THR;
    cfg_data     = '0;
    mismatches   = 0;
    no_idle      = 1'b0;
    hold_request = 0;
    idle_cycles  = 0;
    thr_low      = LOW_THR_RST;
    thr_high     = HIGH_THR_RST;
    range_low    = LOW_RST;
    range_high   = HIGH_RST;
    low_seen     = 1'b0;
    high_seen    = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_zero_span();
    test_fixed_scale();
    test_low_end_learning();
    test_receiver_hold();
    test_sender_pause();
    test_random_phases();

    wait_all_results();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
